[rtl/core/ptmap_pkg.sv]
// ----------------------------------------------------------------------------
// Page table mapper package
// Shared widths, entry masks, result codes and entry helpers.
// ----------------------------------------------------------------------------
package ptmap_pkg;

  localparam int unsigned TABLE_FRAMES_DEF  = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned FRAME_W           = 40;
  localparam int unsigned VA_W              = 48;
  localparam int unsigned PA_W              = 52;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned ADDED_W           = 2;
  localparam int unsigned LEVEL_W           = 2;

  localparam logic [ENTRY_W-1:0] KEEP_MASK  = 64'hfff0_0000_0000_0fff;
  localparam logic [ENTRY_W-1:0] FLAGS_PW   = 64'h0000_0000_0000_0003;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POOL_EMPTY = 2'd1,
    STATUS_BAD_ENTRY  = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [ADDED_W-1:0]   added;
    logic [ENTRY_W-1:0]   leaf;
  } result_t;

  function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [ENTRY_W-1:0] with_frame(input logic [ENTRY_W-1:0] old,
                                                    input logic [FRAME_W-1:0] frame);
    return (old & KEEP_MASK) | {12'd0, frame, 12'd0} | FLAGS_PW;
  endfunction

endpackage

[rtl/core/ptmap_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module ptmap_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ptmap_walk.sv]
// ----------------------------------------------------------------------------
// Page table walker
// Clears the table store, walks four levels, allocates fresh tables and
// writes the new entries back once the whole walk has succeeded.
// ----------------------------------------------------------------------------
module ptmap_walk #(
  parameter int unsigned TABLE_FRAMES = ptmap_pkg::TABLE_FRAMES_DEF,
  localparam int unsigned SW = $clog2(TABLE_FRAMES),
  localparam int unsigned NW = $clog2(TABLE_FRAMES + 1),
  localparam int unsigned DEPTH = TABLE_FRAMES * ptmap_pkg::ENTRIES_PER_TABLE,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ptmap_pkg::FRAME_W-1:0]  base_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ptmap_pkg::VA_W-1:0]     va_i,
  input  logic [ptmap_pkg::PA_W-1:0]     pa_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output ptmap_pkg::result_t             res_o,
  output logic                           mem_we_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_addr_o,
  output logic [ptmap_pkg::ENTRY_W-1:0]  mem_wdata_o,
  input  logic [ptmap_pkg::ENTRY_W-1:0]  mem_rdata_i
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                               state_q, state_d;
  logic [AW-1:0]                        clr_q, clr_d;
  logic [ptmap_pkg::VA_W-1:0]           va_q, va_d;
  logic [ptmap_pkg::FRAME_W-1:0]        pfn_q, pfn_d;
  logic [ptmap_pkg::LEVEL_W-1:0]        lvl_q, lvl_d;
  logic [SW-1:0]                        tbl_q [4];
  logic [SW-1:0]                        tbl_d [4];
  logic [SW-1:0]                        child_q [3];
  logic [SW-1:0]                        child_d [3];
  logic [ptmap_pkg::ENTRY_W-1:0]        entry_q [3];
  logic [ptmap_pkg::ENTRY_W-1:0]        entry_d [3];
  logic [2:0]                           fresh_q, fresh_d;
  logic [NW-1:0]                        nxt_q, nxt_d;
  logic [NW-1:0]                        free_q, free_d;
  logic [ptmap_pkg::ADDED_W-1:0]        added_q, added_d;
  logic [ptmap_pkg::ENTRY_W-1:0]        leaf_q, leaf_d;
  ptmap_pkg::status_e                   status_q, status_d;

  always_comb begin
    logic [ptmap_pkg::FRAME_W-1:0] off;
    logic [SW-1:0]                 child;
    logic                          advance;

    state_d     = state_q;
    clr_d       = clr_q;
    va_d        = va_q;
    pfn_d       = pfn_q;
    lvl_d       = lvl_q;
    tbl_d       = tbl_q;
    child_d     = child_q;
    entry_d     = entry_q;
    fresh_d     = fresh_q;
    nxt_d       = nxt_q;
    free_d      = free_q;
    added_d     = added_q;
    leaf_d      = leaf_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = '0;
    mem_wdata_o = '0;
    off         = mem_rdata_i[51:12] - base_i;
    child       = '0;
    advance     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          va_d       = va_i;
          pfn_d      = pa_i[51:12];
          lvl_d      = '0;
          tbl_d[0]   = '0;
          fresh_d    = '0;
          nxt_d      = free_q;
          added_d    = '0;
          status_d   = ptmap_pkg::STATUS_OK;
          mem_re_o   = 1'b1;
          mem_addr_o = {SW'(0), ptmap_pkg::level_idx(va_i, 2'd0)};
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        if (lvl_q == 2'd3) begin
          leaf_d  = ptmap_pkg::with_frame(mem_rdata_i, pfn_q);
          lvl_d   = '0;
          state_d = S_WRITE;
        end else begin
          entry_d[lvl_q] = mem_rdata_i;
          if (mem_rdata_i[0]) begin
            if (off >= ptmap_pkg::FRAME_W'(TABLE_FRAMES)) begin
              status_d = ptmap_pkg::STATUS_BAD_ENTRY;
              state_d  = S_DONE;
            end else begin
              child   = off[SW-1:0];
              advance = 1'b1;
            end
          end else if (nxt_q >= NW'(TABLE_FRAMES)) begin
            status_d = ptmap_pkg::STATUS_POOL_EMPTY;
            state_d  = S_DONE;
          end else begin
            child          = nxt_q[SW-1:0];
            fresh_d[lvl_q] = 1'b1;
            nxt_d          = nxt_q + NW'(1);
            added_d        = added_q + ptmap_pkg::ADDED_W'(1);
            advance        = 1'b1;
          end
          if (advance) begin
            child_d[lvl_q]       = child;
            tbl_d[lvl_q + 2'd1]  = child;
            lvl_d                = lvl_q + 2'd1;
            mem_re_o             = 1'b1;
            mem_addr_o           = {child, ptmap_pkg::level_idx(va_q, lvl_q + 2'd1)};
          end
        end
      end
      S_WRITE: begin
        mem_addr_o = {tbl_q[lvl_q], ptmap_pkg::level_idx(va_q, lvl_q)};
        if (lvl_q == 2'd3) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = leaf_q;
          state_d     = S_DONE;
        end else begin
          mem_we_o    = fresh_q[lvl_q];
          mem_wdata_o = ptmap_pkg::with_frame(entry_q[lvl_q],
                                              base_i + ptmap_pkg::FRAME_W'(child_q[lvl_q]));
          lvl_d       = lvl_q + 2'd1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (status_q == ptmap_pkg::STATUS_OK) begin
            free_d = nxt_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    res_o.status = status_q;
    res_o.added  = (status_q == ptmap_pkg::STATUS_OK) ? added_q : '0;
    res_o.leaf   = (status_q == ptmap_pkg::STATUS_OK) ? leaf_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      lvl_q    <= '0;
      fresh_q  <= '0;
      nxt_q    <= '0;
      free_q   <= NW'(1);
      added_q  <= '0;
      status_q <= ptmap_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      lvl_q    <= lvl_d;
      fresh_q  <= fresh_d;
      nxt_q    <= nxt_d;
      free_q   <= free_d;
      added_q  <= added_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q    <= va_d;
    pfn_q   <= pfn_d;
    tbl_q   <= tbl_d;
    child_q <= child_d;
    entry_q <= entry_d;
    leaf_q  <= leaf_d;
  end

endmodule

[rtl/core/four_level_page_table_mapper.sv]
// ----------------------------------------------------------------------------
// Four-level page table mapper
// Maps one virtual page per request into a pool of page tables held in a
// single table store, allocating intermediate tables as needed.
//
//   channel   direction  handshake                      payload
//   in        input      in_valid_i / in_ready_o        virtual_address_i, physical_address_i
//   out       output     out_valid_o / out_ready_i      status_o, tables_added_o, leaf_entry_o
//   cfg       input      pool_base_frame_we_i           pool_base_frame_i
//
// A request runs through an accept, 4 dependent table reads, 4 write-back
// steps and a hand-off; a fault ends the walk early. The single store port
// runs them one after another; no new request is taken before the hand-off.
// After reset the store is cleared, all TABLE_FRAMES * 512 entries (8192 by
// default), with in_ready_o low. A result waiting in the output register does
// not stop the next request from being accepted and walked.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper #(
  parameter int unsigned TABLE_FRAMES = ptmap_pkg::TABLE_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pool_base_frame_we_i,
  input  logic [ptmap_pkg::FRAME_W-1:0] pool_base_frame_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptmap_pkg::VA_W-1:0]    virtual_address_i,
  input  logic [ptmap_pkg::PA_W-1:0]    physical_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ptmap_pkg::ADDED_W-1:0] tables_added_o,
  output logic [ptmap_pkg::ENTRY_W-1:0] leaf_entry_o
);

  localparam int unsigned DEPTH = TABLE_FRAMES * ptmap_pkg::ENTRIES_PER_TABLE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [ptmap_pkg::FRAME_W-1:0] base_q;
  logic                          out_valid_q, out_valid_d;
  ptmap_pkg::result_t            out_res_q, out_res_d;
  ptmap_pkg::result_t            res;
  logic                          res_valid;
  logic                          res_ready;
  logic                          mem_we;
  logic                          mem_re;
  logic [AW-1:0]                 mem_addr;
  logic [ptmap_pkg::ENTRY_W-1:0] mem_wdata;
  logic [ptmap_pkg::ENTRY_W-1:0] mem_rdata;

  ptmap_walk #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_i     (base_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .va_i       (virtual_address_i),
    .pa_i       (physical_address_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  ptmap_ram #(
    .WIDTH(ptmap_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pool_base_frame_we_i) begin
        base_q <= pool_base_frame_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign tables_added_o = out_res_q.added;
  assign leaf_entry_o   = out_res_q.leaf;

endmodule

[test/four_level_page_table_mapper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table mapper testbench
// Runs a table of directed mapping requests, then random phases under several
// pool base settings. Random idle gaps are drawn on both channels. A local
// page table model predicts each result, or a directed row gives it, and
// each result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper_test;

  localparam int unsigned POOL_TABLES = ptmap_pkg::TABLE_FRAMES_DEF;
  localparam int unsigned STORE_DEPTH = POOL_TABLES * ptmap_pkg::ENTRIES_PER_TABLE;
  localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PLAN_ROWS = 21;
  localparam int unsigned PHASES = 6;

  typedef enum logic {ROW_MAP, ROW_BASE} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [ptmap_pkg::VA_W-1:0]      va;
    logic [ptmap_pkg::PA_W-1:0]      pa;
    logic [ptmap_pkg::FRAME_W-1:0]   base;
    bit                              typed;
    ptmap_pkg::status_e              exp_status;
    logic [ptmap_pkg::ADDED_W-1:0]   exp_added;
    logic [ptmap_pkg::ENTRY_W-1:0]   exp_leaf;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          base_we = 1'b0;
  logic [ptmap_pkg::FRAME_W-1:0] base_frame = '0;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  logic [ptmap_pkg::VA_W-1:0]    req_va = '0;
  logic [ptmap_pkg::PA_W-1:0]    req_pa = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  logic [1:0]                    rsp_status;
  logic [ptmap_pkg::ADDED_W-1:0] rsp_added;
  logic [ptmap_pkg::ENTRY_W-1:0] rsp_leaf;

  logic [ptmap_pkg::ENTRY_W-1:0] table_mem [STORE_DEPTH];
  int unsigned                   free_slot = 1;
  logic [ptmap_pkg::FRAME_W-1:0] pool_base = '0;
  ptmap_pkg::result_t            pending_maps [$];

  plan_row_t                     plan [PLAN_ROWS];
  logic [ptmap_pkg::FRAME_W-1:0] phase_base [PHASES];
  int unsigned                   phase_items [PHASES];

  bit                  no_idle = 1'b0;
  int unsigned         cycle_count = 0;
  int unsigned         mismatches = 0;
  int unsigned         requests_sent = 0;
  int unsigned         base_writes = 0;
  int unsigned         n_ok = 0;
  int unsigned         n_empty = 0;
  int unsigned         n_bad = 0;

  four_level_page_table_mapper #(
    .TABLE_FRAMES(POOL_TABLES)
  ) DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .pool_base_frame_we_i(base_we),
    .pool_base_frame_i   (base_frame),
    .in_valid_i          (req_valid),
    .in_ready_o          (req_ready),
    .virtual_address_i   (req_va),
    .physical_address_i  (req_pa),
    .out_valid_o         (rsp_valid),
    .out_ready_i         (rsp_ready),
    .status_o            (rsp_status),
    .tables_added_o      (rsp_added),
    .leaf_entry_o        (rsp_leaf)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_maps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [ptmap_pkg::ENTRY_W-1:0] put_frame(
      input logic [ptmap_pkg::ENTRY_W-1:0] old,
      input logic [ptmap_pkg::FRAME_W-1:0] frame);
    return (old & ptmap_pkg::KEEP_MASK) | {12'h000, frame, 12'h003};
  endfunction

  function automatic logic [STORE_AW-1:0] store_pos(input int unsigned slot,
                                                    input logic [ptmap_pkg::IDX_W-1:0] idx);
    return STORE_AW'(slot * ptmap_pkg::ENTRIES_PER_TABLE + 32'(idx));
  endfunction

  function automatic ptmap_pkg::result_t map_page(input logic [ptmap_pkg::VA_W-1:0] va,
                                                  input logic [ptmap_pkg::PA_W-1:0] pa);
    logic [ptmap_pkg::IDX_W-1:0]   idx [4];
    int unsigned                   slot [4];
    bit                            fresh [3];
    int unsigned                   nxt;
    logic [ptmap_pkg::ADDED_W-1:0] added;
    logic [ptmap_pkg::ENTRY_W-1:0] ent;
    logic [ptmap_pkg::FRAME_W-1:0] off;
    logic [STORE_AW-1:0]           pos;
    ptmap_pkg::result_t            res;
    idx[0] = va[47:39];
    idx[1] = va[38:30];
    idx[2] = va[29:21];
    idx[3] = va[20:12];
    nxt = free_slot;
    added = '0;
    slot[0] = 0;
    res = '0;
    res.status = ptmap_pkg::STATUS_OK;
    for (int lvl = 0; lvl < 3; lvl++) begin
      ent = table_mem[store_pos(slot[lvl], idx[lvl])];
      fresh[lvl] = 1'b0;
      if (ent[0]) begin
        off = ent[51:12] - pool_base;
        if (off >= 40'(POOL_TABLES)) begin
          res.status = ptmap_pkg::STATUS_BAD_ENTRY;
          return res;
        end
        slot[lvl+1] = 32'(off);
      end else begin
        if (nxt >= POOL_TABLES) begin
          res.status = ptmap_pkg::STATUS_POOL_EMPTY;
          return res;
        end
        fresh[lvl] = 1'b1;
        slot[lvl+1] = nxt;
        nxt++;
        added++;
      end
    end
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (fresh[lvl]) begin
        pos = store_pos(slot[lvl], idx[lvl]);
        table_mem[pos] = put_frame(table_mem[pos], pool_base + 40'(slot[lvl+1]));
      end
    end
    pos = store_pos(slot[3], idx[3]);
    res.leaf = put_frame(table_mem[pos], pa[51:12]);
    table_mem[pos] = res.leaf;
    res.added = added;
    free_slot = nxt;
    return res;
  endfunction

  function automatic logic [ptmap_pkg::IDX_W-1:0] pick_index();
    logic [31:0] r;
    r = $urandom();
    case (r[2:0])
      3'd0: return 9'd0;
      3'd1: return 9'd1;
      3'd2: return 9'd2;
      3'd3: return 9'd3;
      3'd4: return 9'd5;
      3'd5: return 9'd256;
      3'd6: return 9'd511;
      default: return r[16:8];
    endcase
  endfunction

  task automatic send_map(input logic [ptmap_pkg::VA_W-1:0] va,
                          input logic [ptmap_pkg::PA_W-1:0] pa,
                          input bit typed, input ptmap_pkg::result_t typed_res);
    int unsigned        gap;
    ptmap_pkg::result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_va <= va;
    req_pa <= pa;
    do @(posedge clk); while (req_ready !== 1'b1);
    pred = map_page(va, pa);
    pending_maps.push_back(typed ? typed_res : pred);
    requests_sent++;
  endtask

  task automatic send_random();
    logic [63:0]                 r;
    logic [63:0]                 r2;
    logic [ptmap_pkg::IDX_W-1:0] leaf_idx;
    r = {$urandom(), $urandom()};
    r2 = {$urandom(), $urandom()};
    leaf_idx = r[0] ? pick_index() : r[60:52];
    send_map({pick_index(), pick_index(), pick_index(), leaf_idx, r[11:0]}, r2[51:0],
             1'b0, '0);
  endtask

  task automatic set_pool_base(input logic [ptmap_pkg::FRAME_W-1:0] value);
    req_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    base_we <= 1'b1;
    base_frame <= value;
    @(posedge clk);
    base_we <= 1'b0;
    pool_base = value;
    base_writes++;
  endtask

  task automatic check_result();
    ptmap_pkg::result_t want;
    if (pending_maps.size() == 0) begin
      $error("unexpected result: status %0d tables_added %0d leaf_entry %h",
             rsp_status, rsp_added, rsp_leaf);
      mismatches++;
      return;
    end
    want = pending_maps.pop_front();
    if (rsp_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, rsp_status);
      mismatches++;
    end
    if (rsp_added !== want.added) begin
      $error("tables_added: expected %0d, got %0d", want.added, rsp_added);
      mismatches++;
    end
    if (rsp_leaf !== want.leaf) begin
      $error("leaf_entry: expected %h, got %h", want.leaf, rsp_leaf);
      mismatches++;
    end
    case (want.status)
      ptmap_pkg::STATUS_OK:         n_ok++;
      ptmap_pkg::STATUS_POOL_EMPTY: n_empty++;
      default:                      n_bad++;
    endcase
  endtask

  // Result side: random stall before each result
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      check_result();
    end
  end

  initial begin
    logic [63:0]        r;
    ptmap_pkg::result_t typed_res;
    foreach (table_mem[i]) table_mem[i] = '0;

    plan = '{
      '{ROW_MAP, 48'h0000_0000_0000, 52'h0_0000_0000_0000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_OK, 2'd3, 64'h0000_0000_0000_0003},
      '{ROW_MAP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 40'h0, 1'b1,
        ptmap_pkg::STATUS_OK, 2'd3, 64'h000F_FFFF_FFFF_F003},
      '{ROW_MAP, 48'h0000_0000_0000, 52'hF_FFFF_FFFF_FFFF, 40'h0, 1'b1,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h000F_FFFF_FFFF_F003},
      '{ROW_MAP, 48'hFFFF_FFFF_FFFF, 52'h0_0000_0000_0000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0000_0000_0000_0003},
      '{ROW_MAP, 48'h0000_0000_1000, 52'h0_0000_1234_5000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0000_0020_0000, 52'h5_5555_5555_5000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0000_4000_0000, 52'hA_AAAA_AAAA_A000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0080_0000_0000, 52'h8_0000_0000_0000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0100_0000_0000, 52'h0_0000_0000_1000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0180_0000_0000, 52'h1_2345_6789_A000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_POOL_EMPTY, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0081_4000_0000, 52'hF_FFFF_FFFF_FFFF, 40'h0, 1'b1,
        ptmap_pkg::STATUS_POOL_EMPTY, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0000_0000_0FFF, 52'h0_0000_0000_0FFF, 40'h0, 1'b1,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0000_0000_0000_0003},
      '{ROW_MAP, 48'h8000_0000_0000, 52'h0_0000_0000_0000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_POOL_EMPTY, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0000_001F_F000, 52'h7_FFFF_FFFF_F000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_BASE, 48'h0, 52'h0, 40'h00_0000_0000, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0000_0000_0000, 52'h1_0000_0000_0000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_BAD_ENTRY, 2'd0, 64'h0},
      '{ROW_MAP, 48'hFFFF_FFFF_FFFF, 52'h0_0000_0000_0000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0180_0000_0000, 52'h0_0000_0000_0000, 40'h0, 1'b1,
        ptmap_pkg::STATUS_POOL_EMPTY, 2'd0, 64'h0},
      '{ROW_BASE, 48'h0, 52'h0, 40'hFF_FFFF_FFFF, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0080_0000_0000, 52'h3_0000_0000_0000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0},
      '{ROW_MAP, 48'h0100_0000_0000, 52'hC_0000_0000_0000, 40'h0, 1'b0,
        ptmap_pkg::STATUS_OK, 2'd0, 64'h0}
    };

    r = {$urandom(), $urandom()};
    phase_base = '{40'hFF_FFFF_FFFA, 40'h00_0000_0000, r[39:0], 40'hFF_FFFF_FFF9,
                   40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFA};
    phase_items = '{180, 70, 70, 90, 70, 150};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the store clear after reset is done
    do @(posedge clk); while (req_ready !== 1'b1);

    // wrapping base: slots from six on sit at frames past the top
    set_pool_base(40'hFF_FFFF_FFFA);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_BASE) begin
        set_pool_base(plan[i].base);
      end else begin
        typed_res.status = plan[i].exp_status;
        typed_res.added = plan[i].exp_added;
        typed_res.leaf = plan[i].exp_leaf;
        send_map(plan[i].va, plan[i].pa, plan[i].typed, typed_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_pool_base(phase_base[p]);
      no_idle = (p == 2 || p == 4);
      repeat (phase_items[p]) send_random();
    end
    no_idle = 1'b0;
    req_valid <= 1'b0;

    while (pending_maps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d mapping requests over %0d pool base settings", requests_sent,
             base_writes);
    $display("Results: %0d mapped, %0d pool empty, %0d bad entry; %0d of %0d tables used",
             n_ok, n_empty, n_bad, free_slot, POOL_TABLES);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
